@@ rtl/smm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

  // Store sizes in bytes
  localparam int SEGMENT_BYTES = 4096;
  localparam int STACK_BYTES   = 65536;

  localparam int SEG_AW    = $clog2(SEGMENT_BYTES);
  localparam int STK_AW    = $clog2(STACK_BYTES);
  localparam int CLR_DEPTH = (SEGMENT_BYTES > STACK_BYTES) ? SEGMENT_BYTES : STACK_BYTES;
  localparam int OFF_W     = $clog2(CLR_DEPTH);

  localparam logic [31:0] STACK_BASE = 32'hff7ff000;
  localparam logic [31:0] SEG_LEN    = 32'(SEGMENT_BYTES);
  localparam logic [31:0] STK_LEN    = 32'(STACK_BYTES);

  localparam int NUM_WINDOWS = 4;

  typedef enum logic [1:0] {
    CMD_RD_BYTE = 2'd0,
    CMD_WR_BYTE = 2'd1,
    CMD_RD_WORD = 2'd2,
    CMD_WR_WORD = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_RODATA = 3'd0,
    CFG_TEXT   = 3'd1,
    CFG_DATA   = 3'd2,
    CFG_BSS    = 3'd3,
    CFG_ENDIAN = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEG_RODATA = 3'd0,
    SEG_TEXT   = 3'd1,
    SEG_DATA   = 3'd2,
    SEG_BSS    = 3'd3,
    SEG_STACK  = 3'd4
  } seg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BYTE,
    ST_DRAIN
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic       clear;  // clearing pass, one entry per cycle
    logic       start;  // latch the accepted item
    logic       issue;  // locate byte idx of the access
    logic [1:0] idx;
    logic       load;   // move result into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic word;
    logic busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/segmented_memory_map_unit.sv @@
// Segmented memory map: byte and word access to five emulated windows.
// Channels
//   s_axis  : one beat per access. tuser = command (read byte, write byte,
//             read word, write word); tdata = address, write data.
//   m_axis  : one beat per access. tdata = read data (zero on writes),
//             tuser = unmapped flag.
//   cfg     : window registers (base in upper, length in lower 32 bits) and
//             the endian mode; always ready; write only when idle (not enforced).
// Timing
//   An access is taken only after the previous one has been loaded into the
//   output register; a word access issues its four bytes in turn. Bytes go
//   one per cycle through the window match, the single-port stores and a
//   registered read stage, then into the output register.
// Reset
//   After reset every store is swept to zero, one entry per cycle, over
//   65536 offsets (the larger of segment and stack size); s_axis_tready_o
//   stays low during the sweep, cfg writes are taken.
// Stall
//   A result waits in the output register while m_axis_tready_i is low;
//   the next access is accepted meanwhile and holds before its own load.
`timescale 1ns / 1ps
`default_nettype none

module segmented_memory_map_unit
  import smm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // access stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] address, [63:32] write_data
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] command
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] read_data
  output logic             m_axis_tuser_o    // [0] unmapped
);

  ctrl_cmd_t  ctrl;
  dp_status_t stat;

  // config never backpressures
  assign cfg_ready_o = 1'b1;

  smm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (ctrl)
  );

  smm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_addr_i   (s_axis_tdata_i[31:0]),
    .in_wdata_i  (s_axis_tdata_i[63:32]),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rdata_o     (m_axis_tdata_o),
    .unmapped_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

@@ rtl/smm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smm_ctrl
  import smm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          idx_d       = '0;
          state_d     = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd_o.issue = 1'b1;
        cmd_o.idx   = idx_q;
        idx_d       = idx_q + 2'd1;
        if (!stat_i.word || idx_q == 2'd3) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy && out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/smm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smm_datapath
  import smm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic [1:0]  in_cmd_i,
  input  wire logic [31:0] in_addr_i,
  input  wire logic [31:0] in_wdata_i,
  input  wire ctrl_cmd_t   ctrl_i,
  output dp_status_t       stat_o,
  output logic [31:0]      rdata_o,
  output logic             unmapped_o
);

  // Configuration
  logic [63:0] win_q [NUM_WINDOWS];
  logic        be_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_WINDOWS; k++) begin
        win_q[k] <= '0;
      end
      be_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RODATA: win_q[0] <= cfg_data_i;
        CFG_TEXT:   win_q[1] <= cfg_data_i;
        CFG_DATA:   win_q[2] <= cfg_data_i;
        CFG_BSS:    win_q[3] <= cfg_data_i;
        CFG_ENDIAN: be_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Item registers
  logic [1:0]  cmd_q;
  logic [31:0] addr_q;
  logic [31:0] wdata_q;
  logic        is_word;
  logic        is_write;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q   <= in_cmd_i;
      addr_q  <= in_addr_i;
      wdata_q <= in_wdata_i;
    end
  end

  assign is_word  = (cmd_q == CMD_RD_WORD) || (cmd_q == CMD_WR_WORD);
  assign is_write = (cmd_q == CMD_WR_BYTE) || (cmd_q == CMD_WR_WORD);

  // Locate: window match in priority order
  logic [31:0]      loc_addr;
  logic [31:0]      win_diff [NUM_WINDOWS];
  logic [31:0]      win_len  [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] win_hit;
  logic [31:0]      stk_diff;
  logic             stk_hit;
  logic             loc_hit;
  seg_e             loc_seg;
  logic [OFF_W-1:0] loc_off;
  logic [1:0]       loc_lane;

  always_comb begin
    loc_addr = addr_q + {30'd0, ctrl_i.idx};
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      win_len[k]  = (win_q[k][31:0] > SEG_LEN) ? SEG_LEN : win_q[k][31:0];
      win_diff[k] = loc_addr - win_q[k][63:32];
      win_hit[k]  = (loc_addr >= win_q[k][63:32]) && (win_diff[k] < win_len[k]);
    end
    stk_diff = loc_addr - STACK_BASE;
    stk_hit  = (loc_addr >= STACK_BASE) && (stk_diff < STK_LEN);

    loc_hit = 1'b1;
    loc_seg = SEG_STACK;
    loc_off = OFF_W'(stk_diff[STK_AW-1:0]);
    if (win_hit[0]) begin
      loc_seg = SEG_RODATA;
      loc_off = OFF_W'(win_diff[0][SEG_AW-1:0]);
    end else if (win_hit[1]) begin
      loc_seg = SEG_TEXT;
      loc_off = OFF_W'(win_diff[1][SEG_AW-1:0]);
    end else if (win_hit[2]) begin
      loc_seg = SEG_DATA;
      loc_off = OFF_W'(win_diff[2][SEG_AW-1:0]);
    end else if (win_hit[3]) begin
      loc_seg = SEG_BSS;
      loc_off = OFF_W'(win_diff[3][SEG_AW-1:0]);
    end else if (!stk_hit) begin
      loc_hit = 1'b0;
    end

    // byte lane within the word
    if (!is_word) begin
      loc_lane = 2'd0;
    end else if (be_q) begin
      loc_lane = ~ctrl_i.idx;
    end else begin
      loc_lane = ctrl_i.idx;
    end
  end

  // Stage 1: located byte
  logic             s1_v_q;
  logic             s1_hit_q;
  logic             s1_wr_q;
  seg_e             s1_seg_q;
  logic [OFF_W-1:0] s1_off_q;
  logic [1:0]       s1_lane_q;
  logic [7:0]       s1_byte_q;

  // Stage 2: store read in flight
  logic       s2_v_q;
  logic       s2_hit_q;
  logic       s2_rd_q;
  seg_e       s2_seg_q;
  logic [1:0] s2_lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hit_q  <= loc_hit;
    s1_wr_q   <= is_write;
    s1_seg_q  <= loc_seg;
    s1_off_q  <= loc_off;
    s1_lane_q <= loc_lane;
    s1_byte_q <= wdata_q[{loc_lane, 3'b000} +: 8];
    s2_hit_q  <= s1_hit_q;
    s2_rd_q   <= !s1_wr_q;
    s2_seg_q  <= s1_seg_q;
    s2_lane_q <= s1_lane_q;
  end

  // Clear sweep counter
  logic [OFF_W-1:0] clr_q;
  logic             seg_clr_ok;
  logic             stk_clr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clear) begin
      clr_q <= clr_q + OFF_W'(1);
    end
  end

  assign seg_clr_ok = {1'b0, clr_q} < (OFF_W + 1)'(SEGMENT_BYTES);
  assign stk_clr_ok = {1'b0, clr_q} < (OFF_W + 1)'(STACK_BYTES);

  // Stores
  logic             miss_q;
  logic             wen;
  logic [4:0]       sel;
  logic [OFF_W-1:0] mem_off;
  logic [7:0]       mem_wd;
  logic [7:0]       seg_rd_q [NUM_WINDOWS];
  logic [7:0]       stk_rd_q;

  // a word write stops at the first unmapped byte
  assign wen     = s1_v_q && s1_wr_q && s1_hit_q && !miss_q;
  assign mem_off = ctrl_i.clear ? clr_q : s1_off_q;
  assign mem_wd  = ctrl_i.clear ? 8'd0 : s1_byte_q;

  always_comb begin
    sel = '0;
    case (s1_seg_q)
      SEG_RODATA: sel[0] = 1'b1;
      SEG_TEXT:   sel[1] = 1'b1;
      SEG_DATA:   sel[2] = 1'b1;
      SEG_BSS:    sel[3] = 1'b1;
      SEG_STACK:  sel[4] = 1'b1;
      default:    sel    = '0;
    endcase
  end

  for (genvar g = 0; g < NUM_WINDOWS; g++) begin : g_seg
    logic [7:0] mem [SEGMENT_BYTES];
    logic       we;
    assign we = (ctrl_i.clear && seg_clr_ok) || (wen && sel[g]);
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[mem_off[SEG_AW-1:0]] <= mem_wd;
      end
      seg_rd_q[g] <= mem[mem_off[SEG_AW-1:0]];
    end
  end

  logic [7:0] stk_mem [STACK_BYTES];
  logic       stk_we;
  assign stk_we = (ctrl_i.clear && stk_clr_ok) || (wen && sel[4]);

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[mem_off[STK_AW-1:0]] <= mem_wd;
    end
    stk_rd_q <= stk_mem[mem_off[STK_AW-1:0]];
  end

  // Word assembly
  logic [7:0]  rd_byte;
  logic [31:0] acc_q;

  always_comb begin
    case (s2_seg_q)
      SEG_RODATA: rd_byte = seg_rd_q[0];
      SEG_TEXT:   rd_byte = seg_rd_q[1];
      SEG_DATA:   rd_byte = seg_rd_q[2];
      SEG_BSS:    rd_byte = seg_rd_q[3];
      SEG_STACK:  rd_byte = stk_rd_q;
      default:    rd_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q  <= '0;
      miss_q <= 1'b0;
    end else begin
      if (s1_v_q && !s1_hit_q) begin
        miss_q <= 1'b1;
      end
      if (s2_v_q && s2_rd_q && s2_hit_q) begin
        acc_q[{s2_lane_q, 3'b000} +: 8] <= rd_byte;
      end
    end
  end

  // Output register
  logic [31:0] rdata_q;
  logic        unmapped_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rdata_q    <= acc_q;
      unmapped_q <= miss_q;
    end
  end

  assign rdata_o    = rdata_q;
  assign unmapped_o = unmapped_q;

  assign stat_o.clear_last = (clr_q == OFF_W'(CLR_DEPTH - 1));
  assign stat_o.word       = is_word;
  assign stat_o.busy       = s1_v_q || s2_v_q;

endmodule

`default_nettype wire

@@ rtl/smm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // result beat held under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed under stall");

  // one access at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("second access taken while busy");

  // a result cannot appear in the cycle after its access is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid_o))
    else $error("result raised too early");

endmodule

bind segmented_memory_map_unit smm_checker u_smm_checker (.*);

`default_nettype wire
